[hw/rtl/c8d_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the packet deframer.
// Used by c8d_csr and crc8_packet_deframer; depends on nothing else.
package c8d_pkg;

   // Frame parsing phase
   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_ADDR = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_END  = 3'd4
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_BUSY = 2'd0,
      ST_GOOD = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_MASTER_MODE = 2'd0;
   localparam logic [1:0] REG_OWN_ADDRESS = 2'd1;
   localparam logic [1:0] REG_EXP_LENGTH  = 2'd2;

   localparam int CSR_ADDR_W = 4;

   // Framing bytes and CRC polynomial
   localparam logic [7:0] CRC_POLY     = 8'h07;
   localparam logic [7:0] START_MASTER = 8'h24;
   localparam logic [7:0] START_SLAVE  = 8'h21;
   localparam logic [7:0] TERM_BYTE    = 8'h0A;

   // Configuration seen by the parser
   typedef struct packed {
      logic       master_mode;
      logic [7:0] own_address;
      logic [7:0] expected_length;
   } cfg_type;

   // CRC-8, MSB first, one byte folded in
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hw/rtl/c8d_csr.sv]
// APB-style register file for the deframer: master_mode, own_address, expected_length.
// Depends on c8d_pkg.
module c8d_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [c8d_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output c8d_pkg::cfg_type                cfg
);

   c8d_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // Update the addressed register on a write access
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            c8d_pkg::REG_MASTER_MODE: cfg_in.master_mode     = pwdata[0];
            c8d_pkg::REG_OWN_ADDRESS: cfg_in.own_address     = pwdata[7:0];
            c8d_pkg::REG_EXP_LENGTH:  cfg_in.expected_length = pwdata[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         c8d_pkg::REG_MASTER_MODE: prdata = {31'd0, cfg_ff.master_mode};
         c8d_pkg::REG_OWN_ADDRESS: prdata = {24'd0, cfg_ff.own_address};
         c8d_pkg::REG_EXP_LENGTH:  prdata = {24'd0, cfg_ff.expected_length};
         default:                  prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/crc8_packet_deframer.sv]
// Packet deframer: start, address, length, payload, CRC-8 and newline check.
// Each accepted byte's result item is registered and shows on the rsp channel the next cycle.
// Throughput: one byte per cycle while results are taken; the result register frees
// up as it is taken, and the phase/CRC update is one byte of logic feeding it.
// Reset: synchronous; phase to waiting for start, clears CRC, count and result valid.
// Depends on c8d_pkg and c8d_csr.
module crc8_packet_deframer (
   input  logic                           clock,
   input  logic                           reset,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [c8d_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   // byte input
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   // result output
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_frame_status,
   output logic                           rsp_payload_valid,
   output logic [7:0]                     rsp_payload_byte,
   output logic [7:0]                     rsp_payload_index
);

   c8d_pkg::cfg_type    cfg;
   c8d_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]          crc_ff, crc_in;
   logic [7:0]          count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   c8d_pkg::status_type status_ff, status_in;
   logic                pv_ff, pv_in;
   logic [7:0]          pb_ff, pb_in;
   logic [7:0]          pi_ff, pi_in;
   logic                accept;
   logic [7:0]          start_byte;
   logic [7:0]          crc_next;

   c8d_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Take a new item whenever the result register is empty or being drained
   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign accept     = req_valid & req_ready;
   assign start_byte = cfg.master_mode ? c8d_pkg::START_MASTER : c8d_pkg::START_SLAVE;
   assign crc_next   = c8d_pkg::crc8_update(
                          (phase_ff == c8d_pkg::PH_WAIT) ? 8'd0 : crc_ff, req_rx_byte);

   // Phase decode for one byte
   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      count_in  = count_ff;
      status_in = c8d_pkg::ST_BUSY;
      pv_in     = 1'b0;
      pb_in     = 8'd0;
      pi_in     = 8'd0;
      case (phase_ff)
         c8d_pkg::PH_WAIT: begin
            if (req_rx_byte == start_byte) begin
               crc_in   = crc_next;
               phase_in = c8d_pkg::PH_ADDR;
            end
         end
         c8d_pkg::PH_ADDR: begin
            // drop silently on a foreign address
            if (req_rx_byte == cfg.own_address) begin
               crc_in   = crc_next;
               phase_in = c8d_pkg::PH_LEN;
            end else begin
               phase_in = c8d_pkg::PH_WAIT;
            end
         end
         c8d_pkg::PH_LEN: begin
            if (req_rx_byte == cfg.expected_length) begin
               count_in = 8'd0;
               crc_in   = crc_next;
               phase_in = c8d_pkg::PH_DATA;
            end else begin
               phase_in  = c8d_pkg::PH_WAIT;
               status_in = c8d_pkg::ST_ERR;
            end
         end
         c8d_pkg::PH_DATA: begin
            // payload bytes first, then the CRC byte
            if (count_ff < cfg.expected_length) begin
               pv_in    = 1'b1;
               pb_in    = req_rx_byte;
               pi_in    = count_ff;
               count_in = count_ff + 8'd1;
               crc_in   = crc_next;
            end else if (crc_ff == req_rx_byte) begin
               phase_in = c8d_pkg::PH_END;
            end else begin
               phase_in  = c8d_pkg::PH_WAIT;
               status_in = c8d_pkg::ST_ERR;
            end
         end
         c8d_pkg::PH_END: begin
            status_in = (req_rx_byte == c8d_pkg::TERM_BYTE) ? c8d_pkg::ST_GOOD
                                                             : c8d_pkg::ST_ERR;
            phase_in  = c8d_pkg::PH_WAIT;
         end
         default: begin
            phase_in = c8d_pkg::PH_WAIT;
         end
      endcase
   end

   // Result register valid: set on accept, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= c8d_pkg::PH_WAIT;
         crc_ff       <= 8'd0;
         count_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            crc_ff   <= crc_in;
            count_ff <= count_in;
         end
      end
   end

   // Result payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         pv_ff     <= pv_in;
         pb_ff     <= pb_in;
         pi_ff     <= pi_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_payload_valid = pv_ff;
   assign rsp_payload_byte  = pb_ff;
   assign rsp_payload_index = pi_ff;

   // A payload item never carries a final status
   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload_valid) |-> (rsp_frame_status == c8d_pkg::ST_BUSY))
      else $error("payload item with final status");

   // A final status sends the parser back to waiting for a start byte
   a_status_rewinds: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in != c8d_pkg::ST_BUSY) |=> (phase_ff == c8d_pkg::PH_WAIT))
      else $error("phase not back to wait after final status");

   // Input stalls only while a result is pending
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without pending result");

   // A payload index always lies below the count it leaves behind
   a_index_count: assert property (@(posedge clock) disable iff (reset)
      (accept && pv_in) |=> (count_ff == pi_ff + 8'd1))
      else $error("payload index and byte count disagree");

endmodule
